// File: src/m3inv_pkg.sv
// Shared widths, types and constants for the 3x3 matrix inverse pipeline.
package m3inv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int EW            = 32;              // entry width
    localparam int NENT          = 9;               // entries per matrix
    localparam int DATA_W        = NENT * EW;       // packed matrix width
    localparam int USER_W        = 2;               // singular, saturated
    localparam int PW            = 2 * EW;          // 32x32 product width
    localparam int CW            = PW + 1;          // cross term width
    localparam int LW            = CW + 2;          // sum of three partials
    localparam int DETW          = 98;              // signed determinant width
    localparam int DW            = 96;              // determinant magnitude width
    localparam int RW            = DW + 1;          // divider remainder width
    localparam int QW            = EW;              // quotient bits per entry
    localparam int USR_SINGULAR  = 0;
    localparam int USR_SATURATED = 1;

    localparam logic [EW-1:0] ENT_MAX = {1'b0, {(EW-1){1'b1}}};
    localparam logic [EW-1:0] ENT_MIN = {1'b1, {(EW-1){1'b0}}};

    typedef logic signed [EW-1:0]   t_ent;
    typedef logic signed [PW-1:0]   t_prod;
    typedef logic signed [CW-1:0]   t_cross;
    typedef logic signed [LW-1:0]   t_part;
    typedef logic [DW-1:0]          t_dmag;
    typedef logic [RW-1:0]          t_rem;
    typedef logic [QW-1:0]          t_quo;
    typedef logic [PW-1:0]          t_nmag;

endpackage

// File: src/matrix3x3_inverse.sv
// 3x3 fixed-point matrix inverse by adjugate and pipelined restoring division.
//
//  channel  | dir | payload
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | tdata: c0_r0 .. c2_r2, 32 bits each, column-major
//  m_axis   | out | tdata: inv_c0_r0 .. inv_c2_r2; tuser: singular, saturated
//
// One matrix per cycle while the output is not stalled. Pipeline: six
// arithmetic stages, one overflow check, one stage per quotient bit in nine
// parallel dividers, one output register. The 32 divider stages set the latency.
// Reset clears all valid bits; payload registers are not reset.
// A stall at the output freezes the whole pipeline; nothing is dropped.
module matrix3x3_inverse #(
    parameter int FRAC_BITS = m3inv_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2
    input  logic [m3inv_pkg::DATA_W-1:0]       s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // inv_c0_r0, inv_c0_r1, inv_c0_r2, inv_c1_r0 .. inv_c2_r2
    output logic [m3inv_pkg::DATA_W-1:0]       m_axis_tdata,
    // singular, saturated
    output logic [m3inv_pkg::USER_W-1:0]       m_axis_tuser
);
    import m3inv_pkg::*;

    localparam int NW   = PW + 2 * FRAC_BITS;   // scaled numerator width
    localparam int TW   = NW - QW;              // part above the quotient bits
    localparam int PIPE = 8 + QW;

    logic            en;
    logic [PIPE-1:0] r_vp;

    // stage 1: products
    t_prod r_pa [3][3];
    t_prod r_pb [3][3];
    t_ent  r_m2a [3];
    // stage 2: cross terms
    t_cross r_cr2 [3][3];
    t_ent   r_m2b [3];
    // stage 3: determinant partials
    t_prod  r_pl [3];
    logic signed [PW:0] r_ph [3];
    t_cross r_cr3 [3][3];
    // stage 4: partial sums
    t_part  r_dlo;
    t_part  r_dhi;
    t_cross r_cr4 [3][3];
    // stage 5: determinant, numerator magnitudes
    logic signed [DETW-1:0] r_det;
    t_nmag  r_nm5 [NENT];
    logic   r_nn5 [NENT];
    // stage 6: determinant magnitude
    t_dmag  r_dm6;
    logic   r_dn6;
    logic   r_dz6;
    t_nmag  r_nm6 [NENT];
    logic   r_nn6 [NENT];
    // divider stages 0 .. QW
    t_rem     r_rem [QW+1][NENT];
    t_quo     r_lo  [QW+1][NENT];
    t_quo     r_q   [QW+1][NENT];
    logic     r_ovf [QW+1][NENT];
    logic     r_rn  [QW+1][NENT];
    t_dmag    r_dm  [QW+1];
    logic     r_dz  [QW+1];
    // output register
    logic [DATA_W-1:0] r_odata;
    logic [USER_W-1:0] r_ouser;

    assign en            = !r_vp[PIPE-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vp[PIPE-1];
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= '0;
        end else if (en) begin
            r_vp <= {r_vp[PIPE-2:0], s_axis_tvalid};
        end
    end

    // stages 1..6
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                t_ent a0, a1, a2, b0, b1, b2;
                a0 = t_ent'(s_axis_tdata[(((i+1)%3)*3+0)*EW +: EW]);
                a1 = t_ent'(s_axis_tdata[(((i+1)%3)*3+1)*EW +: EW]);
                a2 = t_ent'(s_axis_tdata[(((i+1)%3)*3+2)*EW +: EW]);
                b0 = t_ent'(s_axis_tdata[(((i+2)%3)*3+0)*EW +: EW]);
                b1 = t_ent'(s_axis_tdata[(((i+2)%3)*3+1)*EW +: EW]);
                b2 = t_ent'(s_axis_tdata[(((i+2)%3)*3+2)*EW +: EW]);
                r_pa[i][0] <= t_prod'(a1) * t_prod'(b2);
                r_pb[i][0] <= t_prod'(a2) * t_prod'(b1);
                r_pa[i][1] <= t_prod'(a2) * t_prod'(b0);
                r_pb[i][1] <= t_prod'(a0) * t_prod'(b2);
                r_pa[i][2] <= t_prod'(a0) * t_prod'(b1);
                r_pb[i][2] <= t_prod'(a1) * t_prod'(b0);
                r_m2a[i]   <= t_ent'(s_axis_tdata[(6+i)*EW +: EW]);
            end

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_cr2[i][j] <= t_cross'(r_pa[i][j]) - t_cross'(r_pb[i][j]);
                end
                r_m2b[i] <= r_m2a[i];
            end

            // split each row-2 cross term into an unsigned low word and a signed high part
            for (int j = 0; j < 3; j++) begin
                logic signed [EW:0]   lo_s;
                logic signed [EW:0]   hi_s;
                logic signed [EW:0]   m_s;
                lo_s = $signed({1'b0, r_cr2[2][j][EW-1:0]});
                hi_s = $signed(r_cr2[2][j][CW-1:EW]);
                m_s  = (EW+1)'(r_m2b[j]);
                r_pl[j] <= t_prod'((PW+2)'(m_s) * (PW+2)'(lo_s));
                r_ph[j] <= (PW+1)'((PW+2)'(m_s) * (PW+2)'(hi_s));
            end
            r_cr3 <= r_cr2;

            r_dlo <= t_part'(r_pl[0]) + t_part'(r_pl[1]) + t_part'(r_pl[2]);
            r_dhi <= t_part'(r_ph[0]) + t_part'(r_ph[1]) + t_part'(r_ph[2]);
            r_cr4 <= r_cr3;

            r_det <= (DETW'(r_dhi) <<< EW) + DETW'(r_dlo);
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    t_cross neg;
                    neg = -r_cr4[i][j];
                    r_nn5[i*3+j] <= r_cr4[i][j][CW-1];
                    r_nm5[i*3+j] <= r_cr4[i][j][CW-1] ? neg[PW-1:0] : r_cr4[i][j][PW-1:0];
                end
            end

            begin
                logic signed [DETW-1:0] dneg_v;
                dneg_v = -r_det;
                r_dn6 <= r_det[DETW-1];
                r_dz6 <= (r_det == '0);
                r_dm6 <= r_det[DETW-1] ? dneg_v[DW-1:0] : r_det[DW-1:0];
            end
            r_nm6 <= r_nm5;
            r_nn6 <= r_nn5;
        end
    end

    // divider: overflow check, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int n = 0; n < NENT; n++) begin
                logic [NW-1:0] num;
                logic [TW-1:0] top;
                num = NW'(r_nm6[n]) << (2 * FRAC_BITS);
                top = num[NW-1:QW];
                r_ovf[0][n] <= (RW'(top) >= RW'(r_dm6));
                r_rem[0][n] <= RW'(top);
                r_lo[0][n]  <= num[QW-1:0];
                r_q[0][n]   <= '0;
                r_rn[0][n]  <= r_nn6[n] ^ r_dn6;
            end
            r_dm[0] <= r_dm6;
            r_dz[0] <= r_dz6;

            for (int k = 1; k <= QW; k++) begin
                for (int n = 0; n < NENT; n++) begin
                    t_rem t;
                    logic ge;
                    t  = {r_rem[k-1][n][RW-2:0], r_lo[k-1][n][QW-1]};
                    ge = (t >= RW'(r_dm[k-1]));
                    r_rem[k][n] <= ge ? t - RW'(r_dm[k-1]) : t;
                    r_lo[k][n]  <= {r_lo[k-1][n][QW-2:0], 1'b0};
                    r_q[k][n]   <= {r_q[k-1][n][QW-2:0], ge};
                    r_ovf[k][n] <= r_ovf[k-1][n];
                    r_rn[k][n]  <= r_rn[k-1][n];
                end
                r_dm[k] <= r_dm[k-1];
                r_dz[k] <= r_dz[k-1];
            end
        end
    end

    // sign, saturate, zero singular results, transpose into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            logic any_sat;
            any_sat = 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    t_quo q;
                    logic rn;
                    logic sat_e;
                    t_quo v;
                    q     = r_q[QW][i*3+j];
                    rn    = r_rn[QW][i*3+j];
                    sat_e = r_ovf[QW][i*3+j] || (rn ? (q > ENT_MIN) : q[QW-1]);
                    if (sat_e) begin
                        v = rn ? ENT_MIN : ENT_MAX;
                    end else begin
                        v = rn ? -q : q;
                    end
                    any_sat = any_sat | sat_e;
                    r_odata[(j*3+i)*EW +: EW] <= r_dz[QW] ? '0 : v;
                end
            end
            r_ouser[USR_SINGULAR]  <= r_dz[QW];
            r_ouser[USR_SATURATED] <= !r_dz[QW] && any_sat;
        end
    end

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USR_SINGULAR] |->
            (m_axis_tdata == '0) && !m_axis_tuser[USR_SATURATED])
        else $error("singular result carries nonzero data or saturation");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vp))
        else $error("pipeline advanced during stall");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vp[PIPE-2] && !r_dz[QW] && !r_ovf[QW][0] |-> (r_rem[QW][0] < RW'(r_dm[QW])))
        else $error("divider remainder not below divisor");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered right after reset");

endmodule

// File: tb/matrix3x3_inverse_tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse pipeline.
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;
    import m3inv_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        logic [DATA_W-1:0] ent;
        logic [USER_W-1:0] flags;
    } t_inv_result;

    // Exact adjugate inverse of one column-major matrix.
    function automatic t_inv_result invert_matrix(input logic [DATA_W-1:0] mat);
        logic signed [127:0] m [3][3];
        logic signed [127:0] cr [3][3];
        logic signed [127:0] det;
        logic [127:0] dmag;
        logic [127:0] nmag;
        logic [127:0] quo;
        logic dneg;
        logic nneg;
        logic rneg;
        logic [EW-1:0] val;
        t_inv_result res;
        int a;
        int b;
        res.ent = '0;
        res.flags = '0;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                m[c][r] = $signed(mat[(c*3+r)*EW +: EW]);
        for (int i = 0; i < 3; i++) begin
            a = (i + 1) % 3;
            b = (i + 2) % 3;
            cr[i][0] = m[a][1] * m[b][2] - m[a][2] * m[b][1];
            cr[i][1] = m[a][2] * m[b][0] - m[a][0] * m[b][2];
            cr[i][2] = m[a][0] * m[b][1] - m[a][1] * m[b][0];
        end
        det = m[2][0] * cr[2][0] + m[2][1] * cr[2][1] + m[2][2] * cr[2][2];
        if (det == 0) begin
            res.flags[USR_SINGULAR] = 1'b1;
            return res;
        end
        dneg = det < 0;
        dmag = dneg ? -det : det;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                nneg = cr[i][j] < 0;
                nmag = nneg ? -cr[i][j] : cr[i][j];
                quo = (nmag << (2 * FB)) / dmag;
                rneg = nneg != dneg;
                if (quo > (rneg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
                    res.flags[USR_SATURATED] = 1'b1;
                    val = rneg ? ENT_MIN : ENT_MAX;
                end else begin
                    val = rneg ? -quo[EW-1:0] : quo[EW-1:0];
                end
                // row i of the inverse lands in column j
                res.ent[(j*3+i)*EW +: EW] = val;
            end
        end
        return res;
    endfunction

    class t_inverse_scoreboard;
        t_inv_result expected_q[$];
        int fails = 0;

        function void note_request(input logic [DATA_W-1:0] mat);
            expected_q.push_back(invert_matrix(mat));
        endfunction

        function void check_result(input logic [DATA_W-1:0] ent,
                                   input logic [USER_W-1:0] flags);
            t_inv_result exp_r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h / %b", $time, ent, flags);
                fails++;
                return;
            end
            exp_r = expected_q.pop_front();
            for (int k = 0; k < NENT; k++)
                if (ent[k*EW +: EW] !== exp_r.ent[k*EW +: EW]) begin
                    $display("%0t: entry %0d expected %h actual %h", $time, k,
                             exp_r.ent[k*EW +: EW], ent[k*EW +: EW]);
                    fails++;
                end
            if (flags[USR_SINGULAR] !== exp_r.flags[USR_SINGULAR]) begin
                $display("%0t: singular expected %b actual %b", $time,
                         exp_r.flags[USR_SINGULAR], flags[USR_SINGULAR]);
                fails++;
            end
            if (flags[USR_SATURATED] !== exp_r.flags[USR_SATURATED]) begin
                $display("%0t: saturated expected %b actual %b", $time,
                         exp_r.flags[USR_SATURATED], flags[USR_SATURATED]);
                fails++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cnt = 0;
    bit hold_go = 0;

    t_inverse_scoreboard sb = new();

    always #10 i_clk = ~i_clk;

    matrix3x3_inverse dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        // c0_r0, c0_r1, c0_r2, c1_r0, c1_r1, c1_r2, c2_r0, c2_r1, c2_r2
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        // inv_c0_r0 .. inv_c2_r2
        .m_axis_tdata(m_axis_tdata),
        // singular, saturated
        .m_axis_tuser(m_axis_tuser)
    );

    // Receiver: random back-pressure plus an optional long hold-off.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
        if (hold_go) begin
            hold_go = 0;
            hold_cnt = 300;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_matrix(input logic [DATA_W-1:0] mat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= mat;
        sb.note_request(mat);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pack9(input logic [EW-1:0] e0, e1, e2,
                                                e3, e4, e5, e6, e7, e8);
        return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
    endfunction

    // Entry in Q16.16 near a small whole value, random fraction.
    function automatic logic [EW-1:0] modest_entry();
        return $signed($urandom_range(16 << FB)) - $signed(8 << FB);
    endfunction

    function automatic logic [DATA_W-1:0] random_matrix();
        logic [DATA_W-1:0] mat;
        int kind;
        kind = $urandom_range(9);
        for (int k = 0; k < NENT; k++)
            mat[k*EW +: EW] = (kind < 6) ? modest_entry() : $urandom();
        if (kind == 6) begin
            // duplicate a column: exactly singular
            mat[2*3*EW +: 3*EW] = mat[0 +: 3*EW];
        end else if (kind == 7) begin
            // tiny raw entries: determinant small, inverse saturates
            for (int k = 0; k < NENT; k++)
                mat[k*EW +: EW] = $signed($urandom_range(8)) - 4;
        end
        return mat;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_matrix(random_matrix());
    endtask

    initial begin
        logic [EW-1:0] one;
        one = 1 << FB;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_matrix(pack9(one, 0, 0, 0, one, 0, 0, 0, one));
        send_matrix(pack9(-one, 0, 0, 0, one, 0, 0, 0, one));
        send_matrix(pack9(2*one, 0, 0, 0, 4*one, 0, 0, 0, -8*one));
        send_matrix('0);
        send_matrix({DATA_W{1'b1}});
        send_matrix(pack9(ENT_MAX, ENT_MAX, ENT_MAX, ENT_MAX, ENT_MAX,
                          ENT_MAX, ENT_MAX, ENT_MAX, ENT_MAX));
        send_matrix(pack9(ENT_MIN, 0, 0, 0, ENT_MIN, 0, 0, 0, ENT_MIN));
        send_matrix(pack9(ENT_MAX, 0, 0, 0, ENT_MIN, 0, 0, 0, ENT_MAX));
        send_matrix(pack9(ENT_MIN, ENT_MAX, 1, ENT_MAX, ENT_MIN, 0, 1, 0, ENT_MIN));
        send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(pack9(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        send_matrix(pack9(one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one,
                          9*one));
        send_matrix(pack9(one, 2*one, 3*one, 0, one, 4*one, 5*one, 6*one, 0));
        send_matrix(pack9(one, one, 0, 0, one, one, one, 0, one));
        send_matrix(pack9(0, one, 0, one, 0, 0, 0, 0, one));
        send_matrix(pack9(3, 1, 4, 1, 5, 9, 2, 6, 5));
        send_matrix(pack9(ENT_MAX, 1, 0, 1, 1, 0, 0, 0, 1));
        send_matrix(pack9(one, 0, 0, 0, one, 0, 0, 0, 1));

        send_idle_pct = 22;
        recv_idle_pct = 76;
        run_random(450);
        send_idle_pct = 76;
        recv_idle_pct = 22;
        run_random(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(400);
        // long output hold-off while input keeps coming: pipeline fills
        hold_go = 1;
        run_random(400);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.fails == 0)
            $display("matrix3x3_inverse_tb passed");
        else
            $display("matrix3x3_inverse_tb failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("matrix3x3_inverse_tb failed");
        $finish;
    end

endmodule

// File: sim.f
src/m3inv_pkg.sv
src/matrix3x3_inverse.sv
tb/matrix3x3_inverse_tb.sv
